>>> rtl/fsc_pkg.sv
`default_nettype none
package fsc_pkg;

  // Feature storage depth, fixed by the 5-bit feature index
  localparam int MAX_FEATURES = 32;
  localparam int FIDX_W       = 5;

  // Configuration register indexes
  localparam logic [1:0] REG_MIN_CAL   = 2'd0;
  localparam logic [1:0] REG_WARN_MULT = 2'd1;
  localparam logic [1:0] REG_CRIT_MULT = 2'd2;
  localparam logic [1:0] REG_FEAT_USE  = 2'd3;

  localparam logic [15:0] MIN_CAL_RST   = 16'd100;
  localparam logic [15:0] WARN_MULT_RST = 16'd512;
  localparam logic [15:0] CRIT_MULT_RST = 16'd768;
  localparam logic [5:0]  FEAT_USE_RST  = 6'd24;

  // Smallest std dev that still yields a z-score
  localparam logic [30:0] STD_FLOOR = 31'd7;

  localparam logic [0:0] KIND_VALUE   = 1'b0;
  localparam logic [0:0] KIND_RESTART = 1'b1;

  typedef struct packed {
    logic [0:0]         kind;
    logic [FIDX_W-1:0]  feature_index;
    logic signed [31:0] sample_value;
    logic               last_feature;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] mean_now;
    logic [30:0]        std_now;
    logic signed [31:0] min_now;
    logic signed [31:0] max_now;
    logic signed [31:0] z_score;
    logic               above_warning;
    logic               above_critical;
    logic               calibrated;
    logic               calibration_completed;
  } out_beat_t;

  // One feature's statistics record
  typedef struct packed {
    logic signed [31:0] mean;
    logic [63:0]        m2;
    logic [30:0]        std;
    logic signed [31:0] min_v;
    logic signed [31:0] max_v;
    logic signed [31:0] warn;
    logic signed [31:0] crit;
  } entry_t;

  localparam entry_t ENTRY_RST = '{
    mean:  32'sd0,
    m2:    64'd0,
    std:   31'd0,
    min_v: 32'sh7FFFFFFF,
    max_v: 32'sh80000000,
    warn:  32'sd0,
    crit:  32'sd0
  };

endpackage
`default_nettype wire

>>> rtl/feature_stats_calibrator_top.sv
`default_nettype none
// Channel   Ports                              Direction
// input     in_valid, in_stall, in_data        item in (value or restart)
// result    out_valid, out_stall, out_data     one beat per item
// config    cfg_we, cfg_index, cfg_wdata       register write, no wait
//
// One item at a time through a shared 64-step restoring divider and a
// 32-step square root; z-score division is skipped for std below 7 LSB,
// variance division and root for the first vector. A calibrating item
// then sweeps the features in use. Synchronous active-low reset; stats
// memory is tracked by per-entry valid bits, so no clearing pass. A stalled
// result waits in the output register while the next item is accepted.
module feature_stats_calibrator_top (
  input  wire                logic clk,
  input  wire                logic rst_n,
  input  wire                logic in_valid,
  output                     logic in_stall,
  input  wire fsc_pkg::in_beat_t  in_data,
  output                     logic out_valid,
  input  wire                logic out_stall,
  output      fsc_pkg::out_beat_t out_data,
  input  wire                logic cfg_we,
  input  wire          logic [1:0] cfg_index,
  input  wire         logic [15:0] cfg_wdata
);
  import fsc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_ZDIV, S_MDIV, S_MUL, S_ACC, S_VDIV, S_SQRT,
    S_WB, S_LRD, S_LMUL, S_LWR, S_OUT
  } state_t;

  state_t state_r;

  logic [15:0] min_cal_r, warn_mult_r, crit_mult_r;
  logic [5:0]  feat_use_r;
  logic [31:0] sample_count_r;
  logic        is_cal_r;
  logic [MAX_FEATURES-1:0] ent_valid_r;

  // statistics memory
  entry_t             mem [MAX_FEATURES];
  entry_t             rdata_r;
  logic [FIDX_W-1:0]  rd_addr, mem_waddr;
  logic               mem_we;
  entry_t             mem_wdata;

  // per-item datapath
  logic [FIDX_W-1:0]  idx_r;
  logic signed [31:0] x_r;
  logic               last_r;
  entry_t             ent_r;
  logic               neg_r;
  logic [31:0]        mag_r;
  logic signed [31:0] z_r, newm_r;
  logic               aw_r, ac_r;
  logic [63:0]        prod_r, m2_r;
  logic [30:0]        std_r;
  out_beat_t          res_r;
  out_beat_t          out_data_r;
  logic               out_valid_r;

  // shared divider
  logic [32:0] div_rem_r, div_den_r;
  logic [63:0] div_quo_r;
  logic [5:0]  div_cnt_r;
  logic [33:0] div_sh;
  logic        div_ge;
  logic [32:0] div_rem_nxt;
  logic [63:0] div_quo_nxt;

  // square root
  logic [33:0] sq_rem_r;
  logic [31:0] sq_root_r;
  logic [63:0] sq_src_r;
  logic [4:0]  sq_cnt_r;
  logic [35:0] sq_sh, sq_trial;
  logic        sq_ge;
  logic [33:0] sq_rem_nxt;
  logic [31:0] sq_root_nxt;

  // threshold latch
  logic [5:0]  lat_cnt_r, feat_cnt;
  entry_t      lat_ent_r;
  logic [46:0] wprod_r, cprod_r;

  // combinational helpers
  entry_t             ent_rd;
  logic signed [32:0] delta;
  logic [32:0]        delta_abs;
  logic signed [32:0] delta2;
  logic [32:0]        delta2_abs;
  logic signed [33:0] newm_sum;
  logic [64:0]        m2_sum;
  logic [32:0]        n_val;
  logic [31:0]        count_nxt;
  logic               cal_hit;
  logic               out_free, in_acc;

  function automatic logic signed [31:0] sat41(input logic signed [40:0] v);
    if (v > 41'sd2147483647) return 32'sh7FFFFFFF;
    else if (v < -41'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  assign feat_cnt  = (feat_use_r > 6'(MAX_FEATURES)) ? 6'(MAX_FEATURES) : feat_use_r;
  assign n_val     = {1'b0, sample_count_r} + 33'd1;
  assign count_nxt = (sample_count_r == 32'hFFFFFFFF) ? sample_count_r
                                                      : sample_count_r + 32'd1;
  // vector end that reaches the calibration count for the first time
  assign cal_hit   = last_r && !is_cal_r && (count_nxt >= {16'd0, min_cal_r});

  // read the entry of the incoming item, else the sweep entry
  assign rd_addr = (state_r == S_IDLE) ? in_data.feature_index : lat_cnt_r[FIDX_W-1:0];
  assign ent_rd  = ent_valid_r[idx_r] ? rdata_r : ENTRY_RST;

  assign delta     = {x_r[31], x_r} - {ent_rd.mean[31], ent_rd.mean};
  assign delta_abs = delta[32] ? 33'(-delta) : 33'(delta);
  assign newm_sum  = {{2{ent_r.mean[31]}}, ent_r.mean}
                   + (neg_r ? -{2'b00, div_quo_nxt[31:0]} : {2'b00, div_quo_nxt[31:0]});
  assign delta2     = {x_r[31], x_r} - {newm_r[31], newm_r};
  assign delta2_abs = delta2[32] ? 33'(-delta2) : 33'(delta2);
  assign m2_sum     = {1'b0, ent_r.m2} + {1'b0, prod_r};

  // divider step: shift one dividend bit into the remainder
  assign div_sh      = {div_rem_r, div_quo_r[63]};
  assign div_ge      = div_sh >= {1'b0, div_den_r};
  assign div_rem_nxt = div_ge ? 33'(div_sh - {1'b0, div_den_r}) : div_sh[32:0];
  assign div_quo_nxt = {div_quo_r[62:0], div_ge};

  // square root step: two radicand bits per step
  assign sq_sh       = {sq_rem_r, sq_src_r[63:62]};
  assign sq_trial    = {2'b00, sq_root_r, 2'b01};
  assign sq_ge       = sq_sh >= sq_trial;
  assign sq_rem_nxt  = sq_ge ? 34'(sq_sh - sq_trial) : sq_sh[33:0];
  assign sq_root_nxt = {sq_root_r[30:0], sq_ge};

  // memory write port
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_r;
    mem_wdata = ent_r;
    case (state_r)
      S_WB: begin
        mem_we          = 1'b1;
        mem_wdata.mean  = newm_r;
        mem_wdata.m2    = m2_r;
        mem_wdata.std   = std_r;
        mem_wdata.min_v = (x_r < ent_r.min_v) ? x_r : ent_r.min_v;
        mem_wdata.max_v = (x_r > ent_r.max_v) ? x_r : ent_r.max_v;
      end
      S_LWR: begin
        mem_we         = 1'b1;
        mem_waddr      = lat_cnt_r[FIDX_W-1:0];
        mem_wdata      = lat_ent_r;
        mem_wdata.warn = sat41({{9{lat_ent_r.mean[31]}}, lat_ent_r.mean}
                               + {2'b00, wprod_r[46:8]});
        mem_wdata.crit = sat41({{9{lat_ent_r.mean[31]}}, lat_ent_r.mean}
                               + {2'b00, cprod_r[46:8]});
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_r <= mem[rd_addr];
  end

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      min_cal_r      <= MIN_CAL_RST;
      warn_mult_r    <= WARN_MULT_RST;
      crit_mult_r    <= CRIT_MULT_RST;
      feat_use_r     <= FEAT_USE_RST;
      sample_count_r <= '0;
      is_cal_r       <= 1'b0;
      ent_valid_r    <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MIN_CAL:   min_cal_r   <= cfg_wdata;
          REG_WARN_MULT: warn_mult_r <= cfg_wdata;
          REG_CRIT_MULT: crit_mult_r <= cfg_wdata;
          REG_FEAT_USE:  feat_use_r  <= cfg_wdata[5:0];
          default:       feat_use_r  <= feat_use_r;
        endcase
      end
      if (mem_we) ent_valid_r[mem_waddr] <= 1'b1;
      // drop a taken beat unless a new one loads this cycle
      if (out_valid_r && !out_stall && state_r != S_OUT) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            idx_r  <= in_data.feature_index;
            x_r    <= in_data.sample_value;
            last_r <= in_data.last_feature;
            if (in_data.kind == KIND_RESTART) begin
              ent_valid_r    <= '0;
              sample_count_r <= '0;
              is_cal_r       <= 1'b0;
              res_r          <= '0;
              state_r        <= S_OUT;
            end else begin
              state_r <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          ent_r     <= ent_rd;
          neg_r     <= delta[32];
          mag_r     <= delta_abs[31:0];
          aw_r      <= x_r > ent_rd.warn;
          ac_r      <= x_r > ent_rd.crit;
          z_r       <= '0;
          div_rem_r <= '0;
          div_cnt_r <= '0;
          if (ent_rd.std >= STD_FLOOR) begin
            div_quo_r <= {16'd0, delta_abs[31:0], 16'd0};
            div_den_r <= {2'b00, ent_rd.std};
            state_r   <= S_ZDIV;
          end else begin
            div_quo_r <= {32'd0, delta_abs[31:0]};
            div_den_r <= n_val;
            state_r   <= S_MDIV;
          end
        end
        S_ZDIV: begin
          div_cnt_r <= div_cnt_r + 6'd1;
          if (div_cnt_r == 6'd63) begin
            if (neg_r)
              z_r <= (div_quo_nxt > 64'h80000000) ? 32'sh80000000
                                                  : 32'(-div_quo_nxt);
            else
              z_r <= (div_quo_nxt > 64'h7FFFFFFF) ? 32'sh7FFFFFFF
                                                  : div_quo_nxt[31:0];
            div_rem_r <= '0;
            div_quo_r <= {32'd0, mag_r};
            div_den_r <= n_val;
            state_r   <= S_MDIV;
          end else begin
            div_rem_r <= div_rem_nxt;
            div_quo_r <= div_quo_nxt;
          end
        end
        S_MDIV: begin
          div_rem_r <= div_rem_nxt;
          div_quo_r <= div_quo_nxt;
          div_cnt_r <= div_cnt_r + 6'd1;
          if (div_cnt_r == 6'd63) begin
            newm_r  <= newm_sum[31:0];
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r  <= mag_r * delta2_abs[31:0];
          state_r <= S_ACC;
        end
        S_ACC: begin
          m2_r <= m2_sum[64] ? 64'hFFFFFFFFFFFFFFFF : m2_sum[63:0];
          if (sample_count_r != 32'd0) begin
            div_rem_r <= '0;
            div_quo_r <= m2_sum[64] ? 64'hFFFFFFFFFFFFFFFF : m2_sum[63:0];
            div_den_r <= {1'b0, sample_count_r};
            div_cnt_r <= '0;
            state_r   <= S_VDIV;
          end else begin
            std_r   <= ent_r.std;
            state_r <= S_WB;
          end
        end
        S_VDIV: begin
          div_rem_r <= div_rem_nxt;
          div_quo_r <= div_quo_nxt;
          div_cnt_r <= div_cnt_r + 6'd1;
          if (div_cnt_r == 6'd63) begin
            sq_src_r  <= div_quo_nxt;
            sq_rem_r  <= '0;
            sq_root_r <= '0;
            sq_cnt_r  <= '0;
            state_r   <= S_SQRT;
          end
        end
        S_SQRT: begin
          sq_rem_r  <= sq_rem_nxt;
          sq_root_r <= sq_root_nxt;
          sq_src_r  <= {sq_src_r[61:0], 2'b00};
          sq_cnt_r  <= sq_cnt_r + 5'd1;
          if (sq_cnt_r == 5'd31) begin
            std_r   <= sq_root_nxt[31] ? 31'h7FFFFFFF : sq_root_nxt[30:0];
            state_r <= S_WB;
          end
        end
        S_WB: begin
          res_r.mean_now              <= newm_r;
          res_r.std_now               <= std_r;
          res_r.min_now               <= mem_wdata.min_v;
          res_r.max_now               <= mem_wdata.max_v;
          res_r.z_score               <= z_r;
          res_r.above_warning         <= aw_r;
          res_r.above_critical        <= ac_r;
          res_r.calibrated            <= is_cal_r || cal_hit;
          res_r.calibration_completed <= cal_hit;
          state_r <= (cal_hit && feat_cnt != 6'd0) ? S_LRD : S_OUT;
          if (last_r) sample_count_r <= count_nxt;
          if (cal_hit) begin
            // start the threshold sweep
            is_cal_r  <= 1'b1;
            lat_cnt_r <= '0;
          end
        end
        S_LRD: state_r <= S_LMUL;
        S_LMUL: begin
          lat_ent_r <= ent_valid_r[lat_cnt_r[FIDX_W-1:0]] ? rdata_r : ENTRY_RST;
          wprod_r   <= warn_mult_r * (ent_valid_r[lat_cnt_r[FIDX_W-1:0]]
                                      ? rdata_r.std : ENTRY_RST.std);
          cprod_r   <= crit_mult_r * (ent_valid_r[lat_cnt_r[FIDX_W-1:0]]
                                      ? rdata_r.std : ENTRY_RST.std);
          state_r   <= S_LWR;
        end
        S_LWR: begin
          lat_cnt_r <= lat_cnt_r + 6'd1;
          state_r   <= (lat_cnt_r + 6'd1 == feat_cnt) ? S_OUT : S_LRD;
        end
        S_OUT: begin
          if (out_free) begin
            out_data_r  <= res_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  // restart leaves no count and no calibration behind
  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.kind == KIND_RESTART |=> sample_count_r == 32'd0 && !is_cal_r)
    else $error("restart did not clear count");

  // a completing beat always reports calibrated
  a_done_implies_cal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.calibration_completed |-> out_data.calibrated)
    else $error("completion without calibration");

  // divider remainder stays below the divisor
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ZDIV || state_r == S_MDIV || state_r == S_VDIV |->
      div_rem_r < div_den_r)
    else $error("divider remainder out of range");

  // a result loads only into a free output register
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT && out_valid_r && out_stall |=> state_r == S_OUT)
    else $error("result overwritten while stalled");
`endif
endmodule
`default_nettype wire

>>> bench/feature_stats_calibrator_top_tb.sv
`timescale 1ns / 1ps
module feature_stats_calibrator_top_tb;
  import fsc_pkg::*;

  // Running-statistics predictor and store of expected result beats
  class stats_board;
    out_beat_t expected_q[$];
    int errors;
    int unsigned min_cal, warn_mult, crit_mult, feat_use;
    int mean_v[MAX_FEATURES];
    longint unsigned m2_v[MAX_FEATURES];
    longint unsigned std_v[MAX_FEATURES];
    int min_v[MAX_FEATURES];
    int max_v[MAX_FEATURES];
    int warn_v[MAX_FEATURES];
    int crit_v[MAX_FEATURES];
    int unsigned vec_count;
    bit cal_done;

    function new();
      errors = 0;
      min_cal = MIN_CAL_RST;
      warn_mult = WARN_MULT_RST;
      crit_mult = CRIT_MULT_RST;
      feat_use = FEAT_USE_RST;
      clear_stats();
    endfunction

    function void clear_stats();
      for (int i = 0; i < MAX_FEATURES; i++) begin
        mean_v[i] = 0;
        m2_v[i] = 0;
        std_v[i] = 0;
        min_v[i] = 32'h7FFFFFFF;
        max_v[i] = 32'h80000000;
        warn_v[i] = 0;
        crit_v[i] = 0;
      end
      vec_count = 0;
      cal_done = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        REG_MIN_CAL:   min_cal = val;
        REG_WARN_MULT: warn_mult = val;
        REG_CRIT_MULT: crit_mult = val;
        REG_FEAT_USE:  feat_use = val[5:0];
        default: ;
      endcase
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function longint sat32(longint v);
      if (v > 64'sh7FFFFFFF) return 64'sh7FFFFFFF;
      if (v < -64'sh80000000) return -64'sh80000000;
      return v;
    endfunction

    // Latch warning and critical levels for the features in use
    function void latch_levels();
      int unsigned cnt;
      longint unsigned tw, tc;
      cnt = (feat_use > MAX_FEATURES) ? MAX_FEATURES : feat_use;
      for (int i = 0; i < cnt; i++) begin
        tw = longint'(warn_mult) * std_v[i];
        tc = longint'(crit_mult) * std_v[i];
        warn_v[i] = sat32(longint'(mean_v[i]) + longint'(tw >> 8));
        crit_v[i] = sat32(longint'(mean_v[i]) + longint'(tc >> 8));
      end
    endfunction

    // Update the statistics for one accepted beat and queue its result
    function void note_input(in_beat_t b);
      out_beat_t e;
      int idx;
      longint x, m, delta, newm, delta2, zv;
      longint unsigned n, s, mag, q, a1, a2, prod, r;
      e = '0;
      if (b.kind == KIND_RESTART) begin
        clear_stats();
        expected_q.push_back(e);
        return;
      end
      idx = b.feature_index;
      x = b.sample_value;
      n = vec_count;
      n = n + 1;
      m = mean_v[idx];
      s = std_v[idx];
      delta = x - m;
      zv = 0;
      if (s >= STD_FLOOR) begin
        mag = (delta < 0) ? -delta : delta;
        q = (mag << 16) / s;
        if (delta < 0) begin
          if (q > 64'h80000000) zv = -64'sh80000000;
          else zv = -longint'(q);
        end else begin
          if (q > 64'h7FFFFFFF) zv = 64'sh7FFFFFFF;
          else zv = q;
        end
      end
      e.above_warning = x > longint'(warn_v[idx]);
      e.above_critical = x > longint'(crit_v[idx]);
      newm = m + delta / longint'(n);
      delta2 = x - newm;
      a1 = (delta < 0) ? -delta : delta;
      a2 = (delta2 < 0) ? -delta2 : delta2;
      prod = a1 * a2;
      if (m2_v[idx] > ~64'd0 - prod) m2_v[idx] = ~64'd0;
      else m2_v[idx] = m2_v[idx] + prod;
      mean_v[idx] = newm;
      if (n > 1) begin
        r = int_sqrt(m2_v[idx] / (n - 1));
        if (r > 64'h7FFFFFFF) r = 64'h7FFFFFFF;
        std_v[idx] = r;
      end
      if (x < longint'(min_v[idx])) min_v[idx] = x;
      if (x > longint'(max_v[idx])) max_v[idx] = x;
      e.mean_now = mean_v[idx];
      e.std_now = std_v[idx][30:0];
      e.min_now = min_v[idx];
      e.max_now = max_v[idx];
      e.z_score = zv[31:0];
      if (b.last_feature) begin
        if (vec_count != 32'hFFFFFFFF) vec_count++;
        if (!cal_done && vec_count >= min_cal) begin
          cal_done = 1;
          latch_levels();
          e.calibration_completed = 1'b1;
        end
      end
      e.calibrated = cal_done;
      expected_q.push_back(e);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("%0t mismatch %s: got %h expected %h", $time, what, got, want);
      errors++;
    endtask

    // Compare one result beat with the oldest expectation
    task check(out_beat_t g);
      out_beat_t e;
      if (expected_q.size() == 0) begin
        report("unexpected beat", g, 0);
        return;
      end
      e = expected_q.pop_front();
      if (g.mean_now !== e.mean_now) report("mean_now", g.mean_now, e.mean_now);
      if (g.std_now !== e.std_now) report("std_now", g.std_now, e.std_now);
      if (g.min_now !== e.min_now) report("min_now", g.min_now, e.min_now);
      if (g.max_now !== e.max_now) report("max_now", g.max_now, e.max_now);
      if (g.z_score !== e.z_score) report("z_score", g.z_score, e.z_score);
      if (g.above_warning !== e.above_warning)
        report("above_warning", g.above_warning, e.above_warning);
      if (g.above_critical !== e.above_critical)
        report("above_critical", g.above_critical, e.above_critical);
      if (g.calibrated !== e.calibrated) report("calibrated", g.calibrated, e.calibrated);
      if (g.calibration_completed !== e.calibration_completed)
        report("calibration_completed", g.calibration_completed, e.calibration_completed);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_beat_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_MIN_CAL;
  logic [15:0] cfg_wdata = '0;

  stats_board board = new();
  bit quiet = 0;
  bit hold_req = 0;
  int base_v[MAX_FEATURES];
  int spread_v[MAX_FEATURES];

  feature_stats_calibrator_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Drive the result stall: mostly open, short stalls, rare long ones
  initial begin : stall_gen
    int r, len;
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (2000) @(posedge clk);
        hold_req = 0;
      end else if (quiet) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          out_stall <= 1'b0;
          len = $urandom_range(1, 20);
        end else if (r < 95) begin
          out_stall <= 1'b1;
          len = $urandom_range(1, 4);
        end else begin
          out_stall <= 1'b1;
          len = $urandom_range(30, 120);
        end
        repeat (len) @(posedge clk);
      end
    end
  end

  // Sample result handshake mid-cycle; the beat lands at the next edge
  initial begin : result_mon
    bit take;
    out_beat_t got;
    forever begin
      @(negedge clk);
      take = rst_n && out_valid && !out_stall;
      got = out_data;
      @(posedge clk);
      if (take) board.check(got);
    end
  end

  task send_beat(in_beat_t b);
    int r, g;
    bit acc;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) g = 0;
    else if (r < 92) g = $urandom_range(1, 3);
    else g = $urandom_range(10, 60);
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do begin
      @(negedge clk);
      acc = !in_stall;
      @(posedge clk);
    end while (!acc);
    board.note_input(b);
  endtask

  task send_value(int idx, int val, bit last);
    in_beat_t b;
    b.kind = KIND_VALUE;
    b.feature_index = idx;
    b.sample_value = val;
    b.last_feature = last;
    send_beat(b);
  endtask

  task send_restart();
    in_beat_t b;
    b.kind = KIND_RESTART;
    b.feature_index = $urandom;
    b.sample_value = $urandom;
    b.last_feature = $urandom;
    send_beat(b);
  endtask

  // Let the block go idle before touching registers
  task drain();
    @(posedge clk);
    in_valid <= 1'b0;
    while (board.expected_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_reg(idx, val);
    @(posedge clk);
  endtask

  task set_all(int mc, int wm, int cm, int fu);
    write_reg(REG_MIN_CAL, mc);
    write_reg(REG_WARN_MULT, wm);
    write_reg(REG_CRIT_MULT, cm);
    write_reg(REG_FEAT_USE, fu);
  endtask

  function int pick_value(int idx);
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return base_v[idx] + $signed($urandom_range(0, 2 * spread_v[idx])) -
                       spread_v[idx];
    if (r < 90) return $urandom;
    case ($urandom_range(0, 3))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 0;
      default: return -1;
    endcase
  endfunction

  // One phase of well-formed vectors with some noise and rare restarts
  task run_phase(int count);
    int sent, len, r;
    for (int i = 0; i < MAX_FEATURES; i++) begin
      base_v[i] = $signed($urandom_range(0, 32'h00FFFFFF)) - 32'h00800000;
      spread_v[i] = $urandom_range(1, 32'h00040000);
    end
    send_restart();
    sent = 1;
    while (sent < count) begin
      r = $urandom_range(0, 99);
      if (r < 2) begin
        send_restart();
        sent++;
      end else if (r < 12) begin
        send_value($urandom_range(0, 31), pick_value($urandom_range(0, 31)), $urandom);
        sent++;
      end else begin
        len = ($urandom_range(0, 19) == 0) ? 32 : $urandom_range(1, 8);
        for (int f = 0; f < len; f++) send_value(f, pick_value(f), f == len - 1);
        sent += len;
      end
    end
    drain();
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed: extremes, one-vector calibration, restart
    set_all(1, 16'hFFFF, 0, 32);
    send_value(0, 32'h7FFFFFFF, 0);
    send_value(31, 32'h80000000, 1);
    send_value(0, 32'h80000000, 0);
    send_value(31, 32'h7FFFFFFF, 1);
    send_value(0, 0, 0);
    send_value(31, -1, 0);
    send_value(7, 32'h00010000, 0);
    send_value(7, 32'h00030000, 1);
    send_value(7, 32'h7FFFFFFF, 1);
    send_value(7, 32'h80000000, 1);
    send_value(0, 32'h00000005, 1);
    send_restart();
    send_value(3, 32'h12345678, 1);
    drain();
    write_reg(REG_MIN_CAL, 0);
    send_value(21, -5, 0);
    send_value(10, 32'h55555555, 0);
    send_value(10, 32'hAAAAAAAA, 1);
    send_value(10, 32'h40000000, 1);
    send_restart();
    drain();

    // Random phases across register settings
    set_all(2, 512, 768, 4);
    run_phase(200);
    set_all(5, 256, 1024, 8);
    hold_req = 1;
    run_phase(200);
    set_all(0, 0, 16'hFFFF, 0);
    run_phase(180);
    quiet = 1;
    set_all(3, 16'hFFFF, 16'hFFFF, 63);
    run_phase(200);
    quiet = 0;
    set_all(16'hFFFF, 700, 900, 32);
    run_phase(150);
    set_all(8, 700, 900, 32);
    run_phase(250);
    set_all(4, 512, 768, 24);
    run_phase(250);

    if (board.errors == 0 && board.expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #40_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
